### rtl/core/urc_pkg.sv
// ----------------------------------------------------------------------------
// urc_pkg: shared types and constants of the UDP receive checker
// Segment summary passed from front to back, verdict codes, register
// indexes and the one's-complement add.
// ----------------------------------------------------------------------------
package urc_pkg;

	localparam int MAX_SEGMENT_BYTES = 2048;
	localparam int NUM_PORT_SLOTS    = 6;
	localparam int HDR_BYTES         = 8;
	localparam int UDP_PROTOCOL      = 17;

	// count saturates at MAX_SEGMENT_BYTES + 1
	localparam int CNT_W     = $clog2(MAX_SEGMENT_BYTES + 2);
	localparam int PLEN_W    = 11;
	localparam int SLOT_W    = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// header field selected by byte position bits [2:1]
	localparam logic [1:0] HDR_SRC = 2'd0;
	localparam logic [1:0] HDR_DST = 2'd1;
	localparam logic [1:0] HDR_LEN = 2'd2;
	localparam logic [1:0] HDR_CHK = 2'd3;

	typedef enum logic [2:0] {
		VERDICT_DELIVERED = 3'd0,
		VERDICT_TOO_SHORT = 3'd1,
		VERDICT_LEN_ERROR = 3'd2,
		VERDICT_BAD_CSUM  = 3'd3,
		VERDICT_PORT_UNR  = 3'd4
	} verdict_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOCAL_IP    = 3'd0,
		CFG_OPEN_PORT_0 = 3'd1
	} cfg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] len;
		logic [15:0]      sum;
		logic [7:0]       held;
		logic [15:0]      source_port;
		logic [15:0]      dest_port;
		logic [15:0]      hdr_length;
		logic [15:0]      hdr_checksum;
		logic [31:0]      sender;
	} seg_sum_t;

	typedef struct packed {
		logic [31:0]                     local_ip;
		logic [NUM_PORT_SLOTS-1:0][15:0] ports;
	} urc_cfg_t;

	function automatic logic [15:0] add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

### rtl/core/urc_front.sv
// ----------------------------------------------------------------------------
// urc_front: byte intake
// Captures header fields, keeps the running one's-complement sum and pushes
// one segment summary per last byte.
// ----------------------------------------------------------------------------
module urc_front import urc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  seg_byte,
	input  logic        is_last,
	input  logic [31:0] sender_ip,
	output logic        push,
	output seg_sum_t    push_rec
);

	logic [CNT_W-1:0] count_q;
	logic [15:0]      sum_q;
	logic [7:0]       held_q;
	logic [15:0]      src_q, dst_q, len_q, chk_q;
	logic [31:0]      sender_q;
	seg_sum_t         nxt;

	always_comb begin
		nxt.len          = count_q;
		nxt.sum          = sum_q;
		nxt.held         = held_q;
		nxt.source_port  = src_q;
		nxt.dest_port    = dst_q;
		nxt.hdr_length   = len_q;
		nxt.hdr_checksum = chk_q;
		nxt.sender       = (count_q == '0) ? sender_ip : sender_q;
		if (count_q < CNT_W'(MAX_SEGMENT_BYTES)) begin
			if (count_q < CNT_W'(HDR_BYTES)) begin
				unique case (count_q[2:1])
					HDR_SRC: nxt.source_port  = {src_q[7:0], seg_byte};
					HDR_DST: nxt.dest_port    = {dst_q[7:0], seg_byte};
					HDR_LEN: nxt.hdr_length   = {len_q[7:0], seg_byte};
					HDR_CHK: nxt.hdr_checksum = {chk_q[7:0], seg_byte};
					default: ;
				endcase
			end
			// checksum field counts as zero: skip its word
			if (!count_q[0]) begin
				nxt.held = seg_byte;
			end else if (count_q != CNT_W'(HDR_BYTES - 1)) begin
				nxt.sum = add16(sum_q, {held_q, seg_byte});
			end
			nxt.len = count_q + CNT_W'(1);
		end else begin
			nxt.len = CNT_W'(MAX_SEGMENT_BYTES + 1);
		end
	end

	assign push     = accept && is_last;
	assign push_rec = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sum_q    <= '0;
			held_q   <= '0;
			src_q    <= '0;
			dst_q    <= '0;
			len_q    <= '0;
			chk_q    <= '0;
			sender_q <= '0;
		end else if (accept) begin
			if (is_last) begin
				count_q  <= '0;
				sum_q    <= '0;
				held_q   <= '0;
				src_q    <= '0;
				dst_q    <= '0;
				len_q    <= '0;
				chk_q    <= '0;
				sender_q <= '0;
			end else begin
				count_q  <= nxt.len;
				sum_q    <= nxt.sum;
				held_q   <= nxt.held;
				src_q    <= nxt.source_port;
				dst_q    <= nxt.dest_port;
				len_q    <= nxt.hdr_length;
				chk_q    <= nxt.hdr_checksum;
				sender_q <= nxt.sender;
			end
		end
	end

endmodule

### rtl/core/urc_fifo.sv
// ----------------------------------------------------------------------------
// urc_fifo: segment summary queue
// Small flop queue that decouples byte intake from verdict evaluation.
// ----------------------------------------------------------------------------
module urc_fifo import urc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  seg_sum_t push_rec,
	input  logic     pop,
	output seg_sum_t head,
	output logic     empty,
	output logic     full
);

	seg_sum_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]     count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (FIFO_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (FIFO_AW+1)'(1);
			end
		end
	end

endmodule

### rtl/core/urc_back.sv
// ----------------------------------------------------------------------------
// urc_back: verdict pipeline
// Folds the pseudo-header into the sum over three stages, searches the open
// ports and registers one result per segment.
// ----------------------------------------------------------------------------
module urc_back import urc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  urc_cfg_t          cfg,
	input  seg_sum_t          head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        verdict,
	output logic [15:0]       source_port,
	output logic [15:0]       dest_port,
	output logic [PLEN_W-1:0] payload_len,
	output logic [SLOT_W-1:0] port_slot
);

	logic adv;
	logic v_s1, v_s2, v_s3, out_valid_q;
	seg_sum_t rec_s1, rec_s2, rec_s3;
	logic [15:0] sum_s2, sum_s3;
	logic        hit_s3;
	logic [SLOT_W-1:0] slot_s3;

	logic [15:0] pad, sum1, sum2, fin;
	logic        hit;
	logic [SLOT_W-1:0] slot;
	logic [CNT_W-1:0]  body_len;
	verdict_t          verdict_d;
	logic [15:0]       sp_d, dp_d;
	logic [PLEN_W-1:0] plen_d;
	logic [SLOT_W-1:0] slot_d;

	logic [2:0]        verdict_q;
	logic [15:0]       sp_q, dp_q;
	logic [PLEN_W-1:0] plen_q;
	logic [SLOT_W-1:0] slot_q;

	// whole pipeline moves together; output register frees it
	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !empty;

	// stage 1: odd-byte pad, sender high word, protocol
	assign pad  = rec_s1.len[0] ? {rec_s1.held, 8'h00} : 16'h0000;
	assign sum1 = add16(add16(add16(rec_s1.sum, pad), rec_s1.sender[31:16]),
		16'(UDP_PROTOCOL));

	// stage 2: sender low word, local address high word, port search
	assign sum2 = add16(add16(sum_s2, rec_s2.sender[15:0]), cfg.local_ip[31:16]);

	always_comb begin
		hit  = 1'b0;
		slot = '0;
		for (int i = NUM_PORT_SLOTS - 1; i >= 0; i--) begin
			if (cfg.ports[i] != 16'h0000 && cfg.ports[i] == rec_s2.dest_port) begin
				hit  = 1'b1;
				slot = SLOT_W'(i);
			end
		end
	end

	// stage 3: local address low word, received length, verdict
	assign fin      = add16(add16(sum_s3, cfg.local_ip[15:0]), 16'(rec_s3.len));
	assign body_len = rec_s3.len - CNT_W'(HDR_BYTES);

	always_comb begin
		verdict_d = VERDICT_DELIVERED;
		sp_d      = rec_s3.source_port;
		dp_d      = rec_s3.dest_port;
		plen_d    = '0;
		slot_d    = '0;
		priority if (rec_s3.len < CNT_W'(HDR_BYTES)) begin
			verdict_d = VERDICT_TOO_SHORT;
			sp_d      = '0;
			dp_d      = '0;
		end else if (rec_s3.len > CNT_W'(MAX_SEGMENT_BYTES)) begin
			verdict_d = VERDICT_LEN_ERROR;
		end else begin
			plen_d = body_len[PLEN_W-1:0];
			priority if ({16'd0, rec_s3.len} < {{CNT_W{1'b0}}, rec_s3.hdr_length}) begin
				verdict_d = VERDICT_LEN_ERROR;
			end else if (~fin != rec_s3.hdr_checksum) begin
				verdict_d = VERDICT_BAD_CSUM;
			end else if (hit_s3) begin
				verdict_d = VERDICT_DELIVERED;
				slot_d    = slot_s3;
			end else begin
				verdict_d = VERDICT_PORT_UNR;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_s1    <= head;
			rec_s2    <= rec_s1;
			sum_s2    <= sum1;
			rec_s3    <= rec_s2;
			sum_s3    <= sum2;
			hit_s3    <= hit;
			slot_s3   <= slot;
			verdict_q <= verdict_d;
			sp_q      <= sp_d;
			dp_q      <= dp_d;
			plen_q    <= plen_d;
			slot_q    <= slot_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= !empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	assign out_valid   = out_valid_q;
	assign verdict     = verdict_q;
	assign source_port = sp_q;
	assign dest_port   = dp_q;
	assign payload_len = plen_q;
	assign port_slot   = slot_q;

endmodule

### rtl/core/udp_receive_checker.sv
// ----------------------------------------------------------------------------
// udp_receive_checker: UDP receive checksum and port check
// Takes a UDP segment one byte per cycle while in_ready is high and gives one verdict per segment.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle, back to back across segment boundaries, as
// long as the four-entry segment queue has room; the running sum is a single
// 16-bit end-around-carry add per byte pair. A segment's summary goes from
// the queue through three stages that fold in the pseudo-header and search
// the six open ports to the output register; a new verdict can follow every
// cycle while out_ready is high. The output register holds a verdict until it
// is taken; while it waits, up to seven finished segments queue behind it
// before in_ready drops. The user writes configuration through cfg_we /
// cfg_index / cfg_wdata while no segment is in flight; it is not enforced.
module udp_receive_checker import urc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            seg_byte,
	input  logic                  is_last,
	input  logic [31:0]           sender_ip,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            verdict,
	output logic [15:0]           source_port,
	output logic [15:0]           dest_port,
	output logic [PLEN_W-1:0]     payload_len,
	output logic [SLOT_W-1:0]     port_slot
);

	urc_cfg_t cfg_q;
	logic     accept, push, pop, empty, full;
	seg_sum_t push_rec, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_LOCAL_IP) begin
				cfg_q.local_ip <= cfg_wdata;
			end
			for (int i = 0; i < NUM_PORT_SLOTS; i++) begin
				if (cfg_index == CFG_IDX_W'(int'(CFG_OPEN_PORT_0) + i)) begin
					cfg_q.ports[i] <= cfg_wdata[15:0];
				end
			end
		end
	end

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	urc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.seg_byte (seg_byte),
		.is_last  (is_last),
		.sender_ip(sender_ip),
		.push     (push),
		.push_rec (push_rec)
	);

	urc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_rec(push_rec),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.full    (full)
	);

	urc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.verdict    (verdict),
		.source_port(source_port),
		.dest_port  (dest_port),
		.payload_len(payload_len),
		.port_slot  (port_slot)
	);

endmodule

### sim/udp_verdict_monitor.sv
// ----------------------------------------------------------------------------
// udp_verdict_monitor: verdict predictor and checker for udp_receive_checker
// Watches the config port and both channels, folds every accepted byte into
// its own segment state, queues the verdict each last byte should produce
// and compares every taken verdict with the oldest one queued.
// ----------------------------------------------------------------------------
module udp_verdict_monitor import urc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [7:0]            seg_byte,
	input  logic                  is_last,
	input  logic [31:0]           sender_ip,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [2:0]            verdict,
	input  logic [15:0]           source_port,
	input  logic [15:0]           dest_port,
	input  logic [PLEN_W-1:0]     payload_len,
	input  logic [SLOT_W-1:0]     port_slot,
	output int                    errors,
	output int                    pending
);

	typedef struct {
		verdict_t          code;
		logic [15:0]       sport;
		logic [15:0]       dport;
		logic [PLEN_W-1:0] plen;
		logic [SLOT_W-1:0] slot;
	} seg_verdict_t;

	seg_verdict_t verdict_q[$];

	logic [31:0]      host_ip;
	logic [15:0]      open_ports [NUM_PORT_SLOTS];
	logic [CNT_W-1:0] seen;
	logic [15:0]      acc;
	logic [7:0]       hi_byte;
	logic [15:0]      hdr_sport, hdr_dport, hdr_len, hdr_csum;
	logic [31:0]      src_ip;

	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		int unsigned t;
		t = a + b;
		t = (t & 32'hFFFF) + (t >> 16);
		return t[15:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch: %s got %0d, want %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		seg_verdict_t want;
		logic [15:0] s;
		int slot_idx;
		bit hit;
		if (!arst_n) begin
			host_ip = '0;
			for (int i = 0; i < NUM_PORT_SLOTS; i++) open_ports[i] = '0;
			seen = '0;
			acc = '0;
			hi_byte = '0;
			hdr_sport = '0;
			hdr_dport = '0;
			hdr_len = '0;
			hdr_csum = '0;
			src_ip = '0;
			verdict_q.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				slot_idx = int'(cfg_index) - int'(CFG_OPEN_PORT_0);
				if (cfg_index == CFG_LOCAL_IP)
					host_ip = cfg_wdata;
				else if (slot_idx >= 0 && slot_idx < NUM_PORT_SLOTS)
					open_ports[slot_idx] = cfg_wdata[15:0];
			end

			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("verdict with nothing pending", verdict, 0);
				end else begin
					want = verdict_q.pop_front();
					if (verdict !== want.code) report_mismatch("verdict", verdict, want.code);
					if (source_port !== want.sport)
						report_mismatch("source_port", source_port, want.sport);
					if (dest_port !== want.dport)
						report_mismatch("dest_port", dest_port, want.dport);
					if (payload_len !== want.plen)
						report_mismatch("payload_len", payload_len, want.plen);
					if (port_slot !== want.slot) report_mismatch("port_slot", port_slot, want.slot);
				end
			end

			if (in_valid && in_ready) begin
				if (seen == 0) src_ip = sender_ip;
				if (seen < MAX_SEGMENT_BYTES) begin
					if (seen < 2)
						hdr_sport = {hdr_sport[7:0], seg_byte};
					else if (seen < 4)
						hdr_dport = {hdr_dport[7:0], seg_byte};
					else if (seen < 6)
						hdr_len = {hdr_len[7:0], seg_byte};
					else if (seen < HDR_BYTES)
						hdr_csum = {hdr_csum[7:0], seg_byte};
					// hold the high byte, add on the low byte; the checksum word counts as zero
					if (!seen[0])
						hi_byte = seg_byte;
					else if (seen != HDR_BYTES - 1)
						acc = oc_add(acc, {hi_byte, seg_byte});
					seen = seen + 1'b1;
				end else begin
					seen = CNT_W'(MAX_SEGMENT_BYTES + 1);
				end

				if (is_last) begin
					want.code = VERDICT_DELIVERED;
					want.sport = '0;
					want.dport = '0;
					want.plen = '0;
					want.slot = '0;
					hit = 1'b0;
					if (seen < HDR_BYTES) begin
						want.code = VERDICT_TOO_SHORT;
					end else if (seen > MAX_SEGMENT_BYTES) begin
						want.code = VERDICT_LEN_ERROR;
						want.sport = hdr_sport;
						want.dport = hdr_dport;
					end else begin
						want.sport = hdr_sport;
						want.dport = hdr_dport;
						want.plen = PLEN_W'(seen - HDR_BYTES);
						if (seen < hdr_len) begin
							want.code = VERDICT_LEN_ERROR;
						end else begin
							s = acc;
							if (seen[0]) s = oc_add(s, {hi_byte, 8'h00});
							s = oc_add(s, src_ip[31:16]);
							s = oc_add(s, src_ip[15:0]);
							s = oc_add(s, host_ip[31:16]);
							s = oc_add(s, host_ip[15:0]);
							s = oc_add(s, 16'(UDP_PROTOCOL));
							s = oc_add(s, 16'(seen));
							if (~s != hdr_csum) begin
								want.code = VERDICT_BAD_CSUM;
							end else begin
								want.code = VERDICT_PORT_UNR;
								// lowest matching slot wins; a zero slot is unused
								for (int i = 0; i < NUM_PORT_SLOTS; i++) begin
									if (!hit && open_ports[i] != 0 && open_ports[i] == hdr_dport) begin
										hit = 1'b1;
										want.code = VERDICT_DELIVERED;
										want.slot = SLOT_W'(i);
									end
								end
							end
						end
					end
					verdict_q.push_back(want);
					seen = '0;
					acc = '0;
					hi_byte = '0;
					hdr_sport = '0;
					hdr_dport = '0;
					hdr_len = '0;
					hdr_csum = '0;
					src_ip = '0;
				end
			end
			pending <= verdict_q.size();
		end
	end

endmodule

### sim/udp_receive_checker_test.sv
// ----------------------------------------------------------------------------
// udp_receive_checker_test: testbench top for the UDP receive checker
// Builds UDP segments (good, short, over-long, bad length, bad checksum,
// closed and zero ports) under several port and address settings, sends them
// with random gaps and output stalls, and reports the monitor's verdict.
// ----------------------------------------------------------------------------
module udp_receive_checker_test;
	import urc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;   // no register behind it
	localparam int TARGET_WORDS  = 1100;
	localparam int STALL_PCT     = 32;
	localparam int DRAIN_CYCLES  = 16;
	localparam int LIMIT_CYCLES  = 200000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            seg_byte;
	logic                  is_last;
	logic [31:0]           sender_ip;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [2:0]            verdict;
	logic [15:0]           source_port;
	logic [15:0]           dest_port;
	logic [PLEN_W-1:0]     payload_len;
	logic [SLOT_W-1:0]     port_slot;
	int                    errors;
	int                    pending;

	int          cycles = 0;
	int          words_sent = 0;
	bit          calm = 1'b0;
	logic [31:0] host_ip;
	logic [15:0] port_table [NUM_PORT_SLOTS];
	logic [7:0]  seg_q[$];
	logic [31:0] seg_sip;

	udp_receive_checker DUT (.*);

	udp_verdict_monitor monitor (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) out_ready <= calm || ($urandom_range(99, 0) >= STALL_PCT);

	// one's-complement sum of pseudo-header and segment, checksum word as zero
	function automatic logic [15:0] fold_segment();
		int unsigned sum;
		int n;
		n = seg_q.size();
		sum = seg_sip[31:16] + seg_sip[15:0] + host_ip[31:16] + host_ip[15:0]
			+ UDP_PROTOCOL + n;
		for (int i = 0; i < n; i += 2)
			if (i != 6) sum += {seg_q[i], (i + 1 < n) ? seg_q[i + 1] : 8'h00};
		while (sum >> 16) sum = (sum & 32'hFFFF) + (sum >> 16);
		return sum[15:0];
	endfunction

	task automatic seal_checksum(input bit good);
		logic [15:0] c;
		c = ~fold_segment();
		if (!good) c ^= 16'($urandom_range(65535, 1));
		seg_q[6] = c[15:8];
		seg_q[7] = c[7:0];
	endtask

	task automatic make_segment(input int n, input logic [31:0] sip, input logic [15:0] dport,
		input logic [15:0] hlen, input bit good);
		logic [15:0] sport;
		sport = 16'($urandom());
		seg_sip = sip;
		seg_q.delete();
		repeat (n) seg_q.push_back(8'($urandom()));
		if (n >= HDR_BYTES) begin
			seg_q[0] = sport[15:8];
			seg_q[1] = sport[7:0];
			seg_q[2] = dport[15:8];
			seg_q[3] = dport[7:0];
			seg_q[4] = hlen[15:8];
			seg_q[5] = hlen[7:0];
			seal_checksum(good);
		end
	endtask

	task automatic send_word(input logic [7:0] b, input logic last, input logic [31:0] sip);
		if (!calm)
			while ($urandom_range(99, 0) < STALL_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		seg_byte <= b;
		is_last <= last;
		sender_ip <= sip;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	// wobble: change the sender address after the first word
	task automatic send_segment(input bit wobble);
		for (int i = 0; i < seg_q.size(); i++)
			send_word(seg_q[i], i == seg_q.size() - 1,
				(i == 0 || !wobble) ? seg_sip : 32'($urandom()));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs();
		cfg_we <= 1'b1;
		cfg_index <= CFG_LOCAL_IP;
		cfg_wdata <= host_ip;
		@(posedge clk);
		for (int i = 0; i < NUM_PORT_SLOTS; i++) begin
			cfg_index <= CFG_IDX_W'(CFG_OPEN_PORT_0 + i);
			cfg_wdata <= {16'($urandom()), port_table[i]};   // upper half is dropped
			@(posedge clk);
		end
		cfg_index <= CFG_SPARE;
		cfg_wdata <= $urandom();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int n;
		int pick;
		int seg_cnt;
		logic [15:0] dport;
		logic [15:0] hlen;
		logic [15:0] pad;
		bit good;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		seg_byte = '0;
		is_last = 1'b0;
		sender_ip = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-ones address, extreme ports, a duplicate pair and an unused slot
		host_ip = 32'hFFFF_FFFF;
		port_table = '{16'hFFFF, 16'h0001, 16'h0000, 16'h1234, 16'h1234, 16'h8000};
		program_regs();

		make_segment(8, 32'h0000_0000, 16'hFFFF, 16'd8, 1'b1);
		send_segment(1'b0);
		make_segment(9, 32'hFFFF_FFFF, 16'h0001, 16'd9, 1'b1);
		send_segment(1'b0);
		make_segment(14, $urandom(), 16'h1234, 16'd14, 1'b1);
		send_segment(1'b0);
		make_segment(12, $urandom(), 16'h8000, 16'd12, 1'b1);
		for (int i = HDR_BYTES; i < 12; i++) seg_q[i] = 8'hFF;
		seal_checksum(1'b1);
		send_segment(1'b0);
		make_segment(10, $urandom(), 16'h8000, 16'd10, 1'b1);
		for (int i = HDR_BYTES; i < 10; i++) seg_q[i] = 8'h00;
		seal_checksum(1'b1);
		send_segment(1'b0);
		make_segment(10, $urandom(), 16'h0000, 16'd10, 1'b1);
		send_segment(1'b0);
		make_segment(10, $urandom(), 16'h0002, 16'd10, 1'b1);
		send_segment(1'b0);
		make_segment(11, $urandom(), 16'h0001, 16'd11, 1'b0);
		send_segment(1'b0);
		make_segment(16, $urandom(), 16'h0001, 16'd17, 1'b1);
		send_segment(1'b0);
		make_segment(8, $urandom(), 16'h0001, 16'hFFFF, 1'b1);
		send_segment(1'b0);
		make_segment(13, $urandom(), 16'h0001, 16'd0, 1'b1);
		send_segment(1'b0);
		make_segment(1, $urandom(), 16'h0001, 16'd1, 1'b1);
		send_segment(1'b0);
		make_segment(7, $urandom(), 16'h0001, 16'd7, 1'b1);
		send_segment(1'b0);
		// pick the last data word so that a zero checksum is the right one
		make_segment(12, $urandom(), 16'hFFFF, 16'd12, 1'b1);
		seg_q[6] = 8'h00;
		seg_q[7] = 8'h00;
		seg_q[10] = 8'h00;
		seg_q[11] = 8'h00;
		pad = 16'hFFFF - fold_segment();
		seg_q[10] = pad[15:8];
		seg_q[11] = pad[7:0];
		send_segment(1'b0);
		make_segment(15, $urandom(), 16'h0001, 16'd15, 1'b1);
		send_segment(1'b1);
		settle();

		// nothing open, zero address
		host_ip = 32'h0000_0000;
		for (int i = 0; i < NUM_PORT_SLOTS; i++) port_table[i] = 16'h0000;
		program_regs();
		make_segment(20, $urandom(), 16'h0001, 16'd20, 1'b1);
		send_segment(1'b0);
		make_segment(9, $urandom(), 16'h0000, 16'd9, 1'b1);
		send_segment(1'b0);
		settle();

		// largest segment, then one two bytes past the limit
		host_ip = $urandom();
		for (int i = 0; i < NUM_PORT_SLOTS; i++) port_table[i] = 16'($urandom()) | 16'h0001;
		program_regs();
		make_segment(MAX_SEGMENT_BYTES, $urandom(), port_table[2], 16'(MAX_SEGMENT_BYTES), 1'b1);
		send_segment(1'b0);
		make_segment(MAX_SEGMENT_BYTES + 2, $urandom(), port_table[0],
			16'(MAX_SEGMENT_BYTES + 2), 1'b1);
		send_segment(1'b0);
		settle();

		words_sent = 0;
		seg_cnt = 0;
		while (words_sent < TARGET_WORDS) begin
			if (seg_cnt % 10 == 0) begin
				settle();
				case ($urandom_range(3, 0))
					0: host_ip = 32'h0000_0000;
					1: host_ip = 32'hFFFF_FFFF;
					default: host_ip = $urandom();
				endcase
				for (int i = 0; i < NUM_PORT_SLOTS; i++) begin
					port_table[i] = ($urandom_range(6, 0) == 0) ? 16'h0000 : 16'($urandom());
					if (i > 0 && $urandom_range(5, 0) == 0)
						port_table[i] = port_table[$urandom_range(i - 1, 0)];
				end
				program_regs();
			end
			calm = (words_sent >= 400 && words_sent < 600);
			pick = $urandom_range(99, 0);
			n = ($urandom_range(19, 0) == 0) ? $urandom_range(200, 41) : $urandom_range(48, 8);
			dport = port_table[$urandom_range(NUM_PORT_SLOTS - 1, 0)];
			hlen = ($urandom_range(4, 0) == 0) ? 16'($urandom_range(n, 0)) : 16'(n);
			good = 1'b1;
			if (pick < 65)
				good = 1'b1;
			else if (pick < 72)
				n = $urandom_range(HDR_BYTES - 1, 1);
			else if (pick < 80)
				good = 1'b0;
			else if (pick < 87)
				hlen = 16'($urandom_range(65535, n + 1));
			else if (pick < 94)
				dport = 16'($urandom());
			else
				dport = 16'h0000;
			make_segment(n, $urandom(), dport, hlen, good);
			send_segment($urandom_range(4, 0) == 0);
			seg_cnt++;
		end
		calm = 1'b0;

		settle();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
